### rtl/aam_pkg.sv
// aam_pkg: shared types, constants and helpers for the angle-axis to
// rotation matrix core. No dependencies.
`timescale 1ns / 1ps
package aam_pkg;

  localparam int ANGLE_FRAC_BITS_DEF  = 28;
  localparam int MATRIX_FRAC_BITS_DEF = 30;

  // internal fixed point: 30 fraction bits
  localparam logic signed [63:0] QONE       = 64'sh0000_0000_4000_0000;
  localparam logic signed [31:0] TWO_PI_Q28 = 32'sh6487_ED51;
  localparam logic [63:0]        INV_TWO_PI = 64'h28BE_60DB_9391_054A;

  localparam int               LIMIT_W     = 29;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 29'd26844;

  // register index of small_angle_limit
  localparam logic [2:0] REG_SMALL_ANGLE_LIMIT = 3'd0;

  // root cell payload
  typedef struct packed {
    logic [33:0] rem;
    logic [63:0] rad;
    logic [31:0] root;
  } sq_t;

  // divider cell payload
  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] low;
    logic [30:0] q;
    logic [31:0] d;
    logic        neg;
    logic        zero;
  } dv_t;

  // series cell payload
  typedef struct packed {
    logic signed [31:0] x2;
    logic signed [33:0] t;
  } hc_t;

  // shift right by 30, half away from zero
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mg;
    mg = v[63] ? 64'(-v) : 64'(v);
    mg = (mg + 64'h2000_0000) >> 30;
    return v[63] ? -$signed(mg) : $signed(mg);
  endfunction

endpackage

### rtl/aam_delay.sv
// aam_delay: enable-gated shift line that keeps side data aligned with
// the compute chains. Depends on nothing.
`timescale 1ns / 1ps
module aam_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[N-1];
endmodule

### rtl/aam_sqrt_cell.sv
// aam_sqrt_cell: one digit of the integer square root (two radicand bits).
// Depends on aam_pkg.
`timescale 1ns / 1ps
module aam_sqrt_cell (
  input  logic         clk,
  input  logic         en,
  input  aam_pkg::sq_t din,
  output aam_pkg::sq_t dout
);
  import aam_pkg::*;

  logic [35:0] cur, trial;

  assign cur   = {din.rem, din.rad[63:62]};
  assign trial = {2'b00, din.root, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rad <= din.rad << 2;
      if (cur >= trial) begin
        dout.rem  <= 34'(cur - trial);
        dout.root <= {din.root[30:0], 1'b1};
      end else begin
        dout.rem  <= cur[33:0];
        dout.root <= {din.root[30:0], 1'b0};
      end
    end
  end
endmodule

### rtl/aam_div_cell.sv
// aam_div_cell: one quotient bit of restoring division.
// Depends on aam_pkg.
`timescale 1ns / 1ps
module aam_div_cell (
  input  logic         clk,
  input  logic         en,
  input  aam_pkg::dv_t din,
  output aam_pkg::dv_t dout
);
  import aam_pkg::*;

  logic [32:0] cur;
  logic        take;

  assign cur  = {din.rem, din.low[30]};
  assign take = cur >= {1'b0, din.d};

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= take ? 32'(cur - {1'b0, din.d}) : cur[31:0];
      dout.low  <= din.low << 1;
      dout.q    <= {din.q[29:0], take};
      dout.d    <= din.d;
      dout.neg  <= din.neg;
      dout.zero <= din.zero;
    end
  end
endmodule

### rtl/aam_horner_cell.sv
// aam_horner_cell: one series step t' = 1 - trunc(round(x2*t) / D), four stages.
// Depends on aam_pkg.
`timescale 1ns / 1ps
module aam_horner_cell #(
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         en,
  input  aam_pkg::hc_t din,
  output aam_pkg::hc_t dout
);
  import aam_pkg::*;

  // floor(2^32 / D): off by at most one, fixed in the last stage
  localparam logic [63:0] RECIP = (64'd1 << 32) / D;

  logic signed [63:0] p1;
  logic signed [31:0] x2_1, x2_2, x2_3;
  logic [31:0]        mg2, mg3;
  logic               neg2, neg3;
  logic [63:0]        p3;
  logic signed [63:0] r2;
  logic [31:0]        q0, rm, q;

  assign r2 = rnd30(p1);
  assign q0 = p3[63:32];
  assign rm = mg3 - 32'(q0 * 32'(D));
  assign q  = (rm >= 32'(D)) ? q0 + 32'd1 : q0;

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= din.x2 * din.t;
      x2_1 <= din.x2;
      mg2  <= r2[63] ? 32'(-r2) : 32'(r2);
      neg2 <= r2[63];
      x2_2 <= x2_1;
      p3   <= 64'(mg2) * RECIP;
      mg3  <= mg2;
      neg3 <= neg2;
      x2_3 <= x2_2;
      dout.x2 <= x2_3;
      dout.t  <= neg3 ? 34'(QONE) + 34'(q) : 34'(QONE) - 34'(q);
    end
  end
endmodule

### rtl/angle_axis_to_rotation_matrix_core.sv
// angle_axis_to_rotation_matrix_core: Rodrigues rotation, rotation vector in,
// 3x3 matrix out. Depends on aam_pkg and the aam_* cell modules.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------
//  in       | in_valid/in_stall  | rot_x, rot_y, rot_z (Q4.28)
//  out      | out_valid/out_stall| m00..m22 (Q2.30), identity_taken
//  config   | APB, pready = 1    | small_angle_limit at byte 0
//
// One transfer per cycle in and out unless stalled; the latency is set by the
// 32-cell root chain followed by the 7-cell cosine series chain.
// Synchronous active-high reset clears the valid pipe, the output valid and
// restores the limit register. A stalled output holds; the pipe keeps moving
// until a result reaches its last stage with the output register still full,
// and only then in_stall rises.
`timescale 1ns / 1ps
module angle_axis_to_rotation_matrix_core #(
  parameter int ANGLE_FRAC_BITS  = aam_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int MATRIX_FRAC_BITS = aam_pkg::MATRIX_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] m00,
  output logic signed [31:0] m01,
  output logic signed [31:0] m02,
  output logic signed [31:0] m10,
  output logic signed [31:0] m11,
  output logic signed [31:0] m12,
  output logic signed [31:0] m20,
  output logic signed [31:0] m21,
  output logic signed [31:0] m22,
  output logic               identity_taken
);
  import aam_pkg::*;

  typedef enum logic [1:0] {QUAD0, QUAD1, QUAD2, QUAD3} quad_t;

  // pipeline map (stage index = registers passed since the input transfer)
  localparam int SQ_CELLS  = 32;
  localparam int DIV_CELLS = 31;
  localparam int SIN_CELLS = 6;
  localparam int COS_CELLS = 7;
  localparam int HC_LAT    = 4;
  localparam int S_ANGLE   = 2 + SQ_CELLS;
  localparam int S_X       = S_ANGLE + 5;
  localparam int S_K       = S_ANGLE + 3;
  localparam int S_X2      = S_ANGLE + 7;
  localparam int S_SINC    = S_X2 + SIN_CELLS * HC_LAT;
  localparam int S_SIN     = S_SINC + 2;
  localparam int S_COS     = S_X2 + COS_CELLS * HC_LAT;
  localparam int S_TRIG    = S_COS + 1;
  localparam int S_W       = S_ANGLE + DIV_CELLS + 2;
  localparam int S_LAST    = S_TRIG + 5;

  localparam int UP = (MATRIX_FRAC_BITS >= 30) ? MATRIX_FRAC_BITS - 30 : 0;
  localparam int DN = (MATRIX_FRAC_BITS < 30) ? 30 - MATRIX_FRAC_BITS : 1;

  // ---------------- configuration ----------------
  logic [LIMIT_W-1:0] limit;
  logic               reg_hit;

  assign reg_hit = (paddr == REG_SMALL_ANGLE_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 32'(limit) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // ---------------- flow control ----------------
  // whole pipe advances together; freeze only when a finished result
  // would collide with an output register still waiting
  logic              en, in_acc, o_valid;
  logic [S_LAST:1]   vld;

  assign en       = !(vld[S_LAST] && o_valid && out_stall);
  assign in_stall = !en;
  assign in_acc   = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_LAST-1:1], in_acc};
    end
  end

  // ---------------- squares and sum ----------------
  logic signed [31:0] a_v [3];
  logic [63:0]        a_sq [3];
  logic [95:0]        b_v;
  logic [63:0]        b_sum;
  logic [31:0]        mg_in [3];

  assign mg_in[0] = rot_x[31] ? 32'(-rot_x) : 32'(rot_x);
  assign mg_in[1] = rot_y[31] ? 32'(-rot_y) : 32'(rot_y);
  assign mg_in[2] = rot_z[31] ? 32'(-rot_z) : 32'(rot_z);

  always_ff @(posedge clk) begin
    if (en) begin
      a_v[0] <= rot_x;
      a_v[1] <= rot_y;
      a_v[2] <= rot_z;
      for (int i = 0; i < 3; i++) a_sq[i] <= 64'(mg_in[i]) * 64'(mg_in[i]);
      b_sum <= a_sq[0] + a_sq[1] + a_sq[2];
      b_v   <= {a_v[2], a_v[1], a_v[0]};
    end
  end

  // ---------------- root chain ----------------
  sq_t sq_c [SQ_CELLS+1];
  assign sq_c[0] = '{rem: '0, rad: b_sum, root: '0};

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
    aam_sqrt_cell u_cell (.clk, .en, .din(sq_c[i]), .dout(sq_c[i+1]));
  end

  logic [31:0] angle;
  logic [95:0] c_v;
  logic        small_c;

  assign angle   = sq_c[SQ_CELLS].root;
  assign small_c = angle < 32'(limit);

  aam_delay #(.W(96), .N(SQ_CELLS)) u_dly_v (.clk, .en, .d(b_v), .q(c_v));

  // ---------------- phase and reduced angle ----------------
  logic [63:0]        t_p0, t_p1;
  logic [64:0]        full;
  logic [31:0]        ph, ru;
  logic [1:0]         k_n, t_k;
  logic signed [31:0] t_r, t_x, t_x2;
  logic signed [63:0] t_rc, t_xx;

  assign full = {1'b0, t_p1} + {33'd0, t_p0[63:32]};
  assign k_n  = 2'((ph + 32'h2000_0000) >> 30);
  assign ru   = ph - {k_n, 30'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      t_p0 <= 64'(angle) * 64'(INV_TWO_PI[31:0]);
      t_p1 <= 64'(angle) * 64'(INV_TWO_PI[63:32]);
      ph   <= full[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
      t_k  <= k_n;
      t_r  <= $signed(ru);
      t_rc <= t_r * TWO_PI_Q28;
      t_x  <= 32'(rnd30(t_rc));
      t_xx <= t_x * t_x;
      t_x2 <= 32'(rnd30(t_xx));
    end
  end

  // ---------------- series chains ----------------
  hc_t sin_c [SIN_CELLS+1];
  hc_t cos_c [COS_CELLS+1];
  assign sin_c[0] = '{x2: t_x2, t: 34'(QONE)};
  assign cos_c[0] = '{x2: t_x2, t: 34'(QONE)};

  for (genvar j = 0; j < SIN_CELLS; j++) begin : g_sin
    localparam int N = SIN_CELLS - j;
    aam_horner_cell #(.D(2 * N * (2 * N + 1))) u_cell (
      .clk, .en, .din(sin_c[j]), .dout(sin_c[j+1]));
  end

  for (genvar j = 0; j < COS_CELLS; j++) begin : g_cos
    localparam int N = COS_CELLS - j;
    aam_horner_cell #(.D((2 * N - 1) * (2 * N))) u_cell (
      .clk, .en, .din(cos_c[j]), .dout(cos_c[j+1]));
  end

  logic [31:0]        x_d;
  logic signed [63:0] s_p;
  logic signed [33:0] s_r;
  logic [33:0]        s_d;
  logic [1:0]         k_d;

  aam_delay #(.W(32), .N(S_SINC - S_X)) u_dly_x (.clk, .en, .d(t_x), .q(x_d));
  aam_delay #(.W(2), .N(S_COS - S_K)) u_dly_k (.clk, .en, .d(t_k), .q(k_d));

  always_ff @(posedge clk) begin
    if (en) begin
      s_p <= $signed(x_d) * sin_c[SIN_CELLS].t;
      s_r <= 34'(rnd30(s_p));
    end
  end

  aam_delay #(.W(34), .N(S_COS - S_SIN)) u_dly_s (.clk, .en, .d(s_r), .q(s_d));

  // quadrant rotation
  logic signed [33:0] sv, cv, sn, cs;
  logic signed [33:0] sn_n, cs_n;
  logic signed [35:0] om;

  assign sv = $signed(s_d);
  assign cv = cos_c[COS_CELLS].t;

  always_comb begin
    case (quad_t'(k_d))
      QUAD0:   begin sn_n = sv;  cs_n = cv;  end
      QUAD1:   begin sn_n = cv;  cs_n = -sv; end
      QUAD2:   begin sn_n = -sv; cs_n = -cv; end
      QUAD3:   begin sn_n = -cv; cs_n = sv;  end
      default: begin sn_n = sv;  cs_n = cv;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= sn_n;
      cs <= cs_n;
      om <= 36'(QONE) - 36'(cs_n);
    end
  end

  // ---------------- unit axis ----------------
  dv_t  dv_c [3][DIV_CELLS+1];
  logic signed [31:0] w_e [3];
  logic [95:0]        w_d;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [31:0] vl;
    logic [31:0]        mg;
    logic [61:0]        nn;
    dv_t                init;
    dv_t                fin;

    assign vl = $signed(c_v[32*l +: 32]);
    assign mg = vl[31] ? 32'(-vl) : 32'(vl);
    assign nn = ({30'd0, mg} << 30) + 62'(angle >> 1);

    always_ff @(posedge clk) begin
      if (en) begin
        init <= '{rem: {1'b0, nn[61:31]}, low: nn[30:0], q: '0, d: angle,
                  neg: vl[31], zero: (angle == 32'd0)};
      end
    end

    assign dv_c[l][0] = init;
    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_dc
      aam_div_cell u_cell (.clk, .en, .din(dv_c[l][i]), .dout(dv_c[l][i+1]));
    end
    assign fin = dv_c[l][DIV_CELLS];

    always_ff @(posedge clk) begin
      if (en) begin
        w_e[l] <= fin.zero ? 32'sd0 : (fin.neg ? -$signed({1'b0, fin.q}) :
                                                  $signed({1'b0, fin.q}));
      end
    end
  end

  aam_delay #(.W(96), .N(S_TRIG - S_W)) u_dly_w (
    .clk, .en, .d({w_e[2], w_e[1], w_e[0]}), .q(w_d));

  logic flag_t;
  aam_delay #(.W(1), .N(S_TRIG - S_ANGLE)) u_dly_f (
    .clk, .en, .d(small_c), .q(flag_t));

  // ---------------- matrix assembly ----------------
  logic signed [31:0] w [3];
  assign w[0] = $signed(w_d[31:0]);
  assign w[1] = $signed(w_d[63:32]);
  assign w[2] = $signed(w_d[95:64]);

  // pair order: 00 01 02 11 12 22
  logic signed [63:0] pww [6], pws [3], pwo [6];
  logic signed [33:0] ww [6], ws2 [3], ws3 [3], ws4 [3], wo [6];
  logic signed [35:0] om1, om2;
  logic signed [33:0] cs1, cs2, cs3, cs4;
  logic               f1, f2, f3, f4, f5;
  logic signed [31:0] ent [9];

  always_ff @(posedge clk) begin
    if (en) begin
      pww[0] <= w[0] * w[0];
      pww[1] <= w[0] * w[1];
      pww[2] <= w[0] * w[2];
      pww[3] <= w[1] * w[1];
      pww[4] <= w[1] * w[2];
      pww[5] <= w[2] * w[2];
      for (int i = 0; i < 3; i++) pws[i] <= w[i] * sn;
      om1 <= om;
      cs1 <= cs;
      f1  <= flag_t;
      for (int i = 0; i < 6; i++) ww[i] <= 34'(rnd30(pww[i]));
      for (int i = 0; i < 3; i++) ws2[i] <= 34'(rnd30(pws[i]));
      om2 <= om1;
      cs2 <= cs1;
      f2  <= f1;
      for (int i = 0; i < 6; i++) pwo[i] <= ww[i] * om2;
      ws3 <= ws2;
      cs3 <= cs2;
      f3  <= f2;
      for (int i = 0; i < 6; i++) wo[i] <= 34'(rnd30(pwo[i]));
      ws4 <= ws3;
      cs4 <= cs3;
      f4  <= f3;
    end
  end

  // final sums, identity select, saturate, output format
  logic signed [35:0] e [9];
  logic signed [35:0] sel [9];
  logic signed [31:0] sat [9];
  logic [63:0]        mgo [9];
  logic [63:0]        ov [9];
  logic [31:0]        ent_n [9];

  always_comb begin
    e[0] = 36'(cs4) + 36'(wo[0]);
    e[1] = 36'(wo[1]) - 36'(ws4[2]);
    e[2] = 36'(wo[2]) + 36'(ws4[1]);
    e[3] = 36'(wo[1]) + 36'(ws4[2]);
    e[4] = 36'(cs4) + 36'(wo[3]);
    e[5] = 36'(wo[4]) - 36'(ws4[0]);
    e[6] = 36'(wo[2]) - 36'(ws4[1]);
    e[7] = 36'(wo[4]) + 36'(ws4[0]);
    e[8] = 36'(cs4) + 36'(wo[5]);
    for (int i = 0; i < 9; i++) begin
      if (f4) sel[i] = (i % 4 == 0) ? 36'(QONE) : 36'sd0;
      else    sel[i] = e[i];
      if (sel[i] > 36'(QONE))       sat[i] = 32'(QONE);
      else if (sel[i] < -36'(QONE)) sat[i] = -32'(QONE);
      else                          sat[i] = 32'(sel[i]);
      mgo[i] = sat[i][31] ? 64'(-sat[i]) : 64'(sat[i]);
      if (MATRIX_FRAC_BITS >= 30) begin
        ov[i] = 64'(sat[i]) << UP;
      end else begin
        ov[i] = (mgo[i] + (64'd1 << (DN - 1))) >> DN;
        if (sat[i][31]) ov[i] = -ov[i];
      end
      ent_n[i] = ov[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) ent[i] <= $signed(ent_n[i]);
      f5 <= f4;
    end
  end

  // ---------------- output register ----------------
  logic signed [31:0] o_m [9];
  logic               o_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en && vld[S_LAST]) begin
      o_valid <= 1'b1;
    end else if (!out_stall) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[S_LAST]) begin
      o_m  <= ent;
      o_id <= f5;
    end
  end

  assign out_valid      = o_valid;
  assign m00            = o_m[0];
  assign m01            = o_m[1];
  assign m02            = o_m[2];
  assign m10            = o_m[3];
  assign m11            = o_m[4];
  assign m12            = o_m[5];
  assign m20            = o_m[6];
  assign m21            = o_m[7];
  assign m22            = o_m[8];
  assign identity_taken = o_id;
endmodule

### rtl/aam_checker.sv
// aam_checker: port-level assertions for the rotation matrix core, plus
// the bind that attaches it. Depends on angle_axis_to_rotation_matrix_core.
`timescale 1ns / 1ps
module aam_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] m00,
  input logic signed [31:0] m01,
  input logic signed [31:0] m02,
  input logic signed [31:0] m10,
  input logic signed [31:0] m11,
  input logic signed [31:0] m12,
  input logic signed [31:0] m20,
  input logic signed [31:0] m21,
  input logic signed [31:0] m22,
  input logic               identity_taken
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(m00) && $stable(m12) && $stable(identity_taken))
    else $error("stalled result changed");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && identity_taken |-> m01 == 0 && m02 == 0 && m10 == 0 && m12 == 0 &&
      m20 == 0 && m21 == 0 && m00 == m11 && m11 == m22)
    else $error("identity flag with non-identity matrix");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
endmodule

bind angle_axis_to_rotation_matrix_core aam_checker u_aam_checker (.*);

### test/angle_axis_to_rotation_matrix_core_tb.sv
// Self-checking testbench for angle_axis_to_rotation_matrix_core: a directed table
// followed by random rotation vectors, checked against a Rodrigues predictor.
// Depends on aam_pkg and the core RTL.
`timescale 1ns / 1ps
module angle_axis_to_rotation_matrix_core_tb;
  import aam_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;   // comfortably above the core latency
  localparam int N_RANDOM = 650;
  localparam logic [31:0] PI_Q28 = 32'd843314857;
  localparam logic [2:0] ADDR_LIMIT = {REG_SMALL_ANGLE_LIMIT[0], 2'b00};
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [8:0][31:0] m;   // row-major, m[0] = m00
    logic             id;
  } matrix_t;

  typedef struct {
    bit          do_cfg;     // drain, then write addr/wdata before this row
    logic [2:0]  addr;
    logic [31:0] wdata;
    logic [31:0] x, y, z;
    bit          known;      // expected result is the identity typed in below
    bit          taken;
  } vec_row_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic signed [31:0] rot_x, rot_y, rot_z;
  logic out_valid, out_stall;
  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic identity_taken;

  angle_axis_to_rotation_matrix_core u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22), .identity_taken(identity_taken)
  );

  matrix_t pending_mats[$];
  logic [28:0] angle_limit;   // testbench copy of the limit register
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_identity = 0;
  int cycle = 0;
  bit known_next = 0;         // next accepted transfer uses typed expectation
  bit known_taken = 0;

  // 12 ns clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor: Rodrigues formula in Q.30 fixed point
  // ---------------------------------------------------------------------
  // shift right with rounding half away from zero
  function automatic longint round_shr(longint v, int sh);
    logic [63:0] mg;
    mg = (v < 0) ? 64'(-v) : 64'(v);
    mg = (mg + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mg) : longint'(mg);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shr(a * b, 30);
  endfunction

  function automatic matrix_t rodrigues(logic [31:0] vx, logic [31:0] vy,
                                        logic [31:0] vz, logic [28:0] lim);
    longint v[3], w[3], m[9];
    longint sn, cs, om, r, x, x2, ts, tc, s, qone;
    logic [63:0] sum, a, ang, res, bt, rem, q;
    logic [127:0] prod;
    logic [31:0] ph, ru, kr;
    logic [1:0] k;
    matrix_t o;
    qone = longint'(QONE);
    v[0] = longint'($signed(vx));
    v[1] = longint'($signed(vy));
    v[2] = longint'($signed(vz));
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      sum += a * a;
    end
    // exact integer square root
    rem = sum;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt >>= 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    ang = res;
    if (ang < {35'd0, lim}) begin
      for (int i = 0; i < 9; i++) o.m[i] = (i % 4 == 0) ? 32'h4000_0000 : 32'd0;
      o.id = 1'b1;
      return o;
    end
    // turn fraction, quadrant, residual in radians
    prod = {64'd0, ang} * {64'd0, INV_TWO_PI};
    ph = prod[91:60];
    kr = ph + 32'h2000_0000;
    k = kr[31:30];
    ru = ph - {k, 30'd0};
    r = longint'($signed(ru));
    x = round_shr(r * longint'(TWO_PI_Q28), 30);
    x2 = qmul(x, x);
    ts = qone;
    tc = qone;
    for (int n = 6; n >= 1; n--) ts = qone - qmul(x2, ts) / longint'((2 * n) * (2 * n + 1));
    for (int n = 7; n >= 1; n--) tc = qone - qmul(x2, tc) / longint'((2 * n - 1) * (2 * n));
    s = qmul(x, ts);
    case (k)
      2'd0: begin sn = s;   cs = tc;  end
      2'd1: begin sn = tc;  cs = -s;  end
      2'd2: begin sn = -s;  cs = -tc; end
      default: begin sn = -tc; cs = s; end
    endcase
    om = qone - cs;
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      if (ang == 0) begin
        w[i] = 0;
      end else begin
        q = ((a << 30) + (ang >> 1)) / ang;
        w[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    m[0] = cs + qmul(qmul(w[0], w[0]), om);
    m[1] = qmul(qmul(w[0], w[1]), om) - qmul(w[2], sn);
    m[2] = qmul(qmul(w[0], w[2]), om) + qmul(w[1], sn);
    m[3] = qmul(qmul(w[1], w[0]), om) + qmul(w[2], sn);
    m[4] = cs + qmul(qmul(w[1], w[1]), om);
    m[5] = qmul(qmul(w[1], w[2]), om) - qmul(w[0], sn);
    m[6] = qmul(qmul(w[2], w[0]), om) - qmul(w[1], sn);
    m[7] = qmul(qmul(w[2], w[1]), om) + qmul(w[0], sn);
    m[8] = cs + qmul(qmul(w[2], w[2]), om);
    for (int i = 0; i < 9; i++) begin
      if (m[i] > qone) m[i] = qone;
      if (m[i] < -qone) m[i] = -qone;
      o.m[i] = m[i][31:0];
    end
    o.id = 1'b0;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: predict on input transfer, check on output transfer
  // ---------------------------------------------------------------------
  string entry_names[9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  always @(posedge clk) begin
    matrix_t exp_mat, got;
    if (!rst && in_valid && !in_stall) begin
      if (known_next) begin
        for (int i = 0; i < 9; i++) exp_mat.m[i] = (i % 4 == 0) ? 32'h4000_0000 : 32'd0;
        exp_mat.id = known_taken;
      end else begin
        exp_mat = rodrigues(rot_x, rot_y, rot_z, angle_limit);
      end
      pending_mats.push_back(exp_mat);
    end
    if (!rst && out_valid && !out_stall) begin
      got.m = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
      got.id = identity_taken;
      if (pending_mats.size() == 0) begin
        $error("output transfer with no expected matrix pending");
        n_errors++;
      end else begin
        exp_mat = pending_mats.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.m[i] !== exp_mat.m[i]) begin
            $error("%s expected %h got %h", entry_names[i], exp_mat.m[i], got.m[i]);
            n_errors++;
          end
        if (got.id !== exp_mat.id) begin
          $error("identity_taken expected %b got %b", exp_mat.id, got.id);
          n_errors++;
        end
        if (got.id === 1'b1) n_identity++;
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall pattern in phases, plus one long hold-off
  // ---------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      // long hold: block fills up and must push back on its input
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_sent >= 120) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);   // pready is high: write lands at this edge
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LIMIT) angle_limit = data[28:0];
  endtask

  // wait for all results, then let the pipe settle
  task automatic drain();
    @(posedge clk);
    while (pending_mats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input bit known, input bit taken);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rot_x <= x;
    rot_y <= y;
    rot_z <= z;
    // updated with the payload so the monitor never sees the next row's flag
    known_next <= known;
    known_taken <= taken;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic [31:0] rand_vec_comp(int shape);
    logic [31:0] v;
    case (shape)
      0: v = $urandom();                                          // full range
      1: v = $urandom_range(0, 60000) - 30000;                    // near threshold
      2: v = $urandom_range(0, 2 * 268435456) - 268435456;        // within one radian
      3: v = $urandom_range(0, 2 * PI_Q28) - PI_Q28;              // within pi
      default: v = ($urandom_range(0, 1) ? PI_Q28 / 2 : -(PI_Q28 / 2))
                   * $urandom_range(1, 4) + $urandom_range(0, 16) - 8;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table: extremes, threshold edges, zero vector, quadrants
  // ---------------------------------------------------------------------
  vec_row_t vec_table[] = '{
    '{0, 0, 0, 32'd0, 32'd0, 32'd0, 1, 1},                    // zero vector, reset limit
    '{0, 0, 0, 32'd1, 32'd0, 32'd0, 1, 1},
    '{0, 0, 0, -32'sd26843, 32'd0, 32'd0, 1, 1},              // just under the limit
    '{0, 0, 0, 32'd26844, 32'd0, 32'd0, 0, 0},                // exactly at the limit
    '{0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0},
    '{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0},
    '{0, 0, 0, 32'h8000_0000, 32'd0, 32'd0, 0, 0},
    '{0, 0, 0, 32'd0, 32'h7FFF_FFFF, 32'd0, 0, 0},
    '{0, 0, 0, 32'd0, 32'd0, 32'h8000_0000, 0, 0},
    '{0, 0, 0, PI_Q28, 32'd0, 32'd0, 0, 0},
    '{0, 0, 0, 32'd0, -32'sd421657428, 32'd0, 0, 0},           // -pi/2 about y
    '{0, 0, 0, 32'd0, 32'd0, 32'd1686629713, 0, 0},           // 2 pi about z
    '{0, 0, 0, 32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F, 0, 0},
    // limit zero: the zero vector passes the threshold test, axis is zero
    '{1, ADDR_LIMIT, 32'd0, 32'd0, 32'd0, 32'd0, 1, 0},
    '{0, 0, 0, 32'd1, 32'd1, 32'd1, 0, 0},
    // limit set to one radian
    '{1, ADDR_LIMIT, 32'd268435456, 32'd268435455, 32'd0, 32'd0, 1, 1},
    '{0, 0, 0, 32'd0, 32'd268435456, 32'd0, 0, 0},
    // upper register bits are dropped
    '{1, ADDR_LIMIT, 32'hE000_03E8, 32'd999, 32'd0, 32'd0, 1, 1},
    '{0, 0, 0, 32'd1000, 32'd0, 32'd0, 0, 0},
    // write to an unused address leaves the limit alone
    '{1, ADDR_UNUSED, 32'd0, 32'd0, 32'd999, 32'd0, 1, 1}
  };

  initial begin
    int shape;
    logic [31:0] lim_choice;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; rot_x = '0; rot_y = '0; rot_z = '0;
    angle_limit = LIMIT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vec_table[i]) begin
      if (vec_table[i].do_cfg) begin
        in_valid <= 1'b0;
        drain();
        apb_write(vec_table[i].addr, vec_table[i].wdata);
      end
      send_vector(vec_table[i].x, vec_table[i].y, vec_table[i].z,
                  vec_table[i].known, vec_table[i].taken);
    end

    // random phases, each under its own limit setting
    for (int phase = 0; phase < 5; phase++) begin
      in_valid <= 1'b0;
      drain();
      case (phase)
        0: lim_choice = LIMIT_RESET;
        1: lim_choice = $urandom();
        2: lim_choice = 32'd0;
        3: lim_choice = 32'd268435456;
        default: lim_choice = $urandom_range(0, 40000);
      endcase
      apb_write(ADDR_LIMIT, lim_choice);
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        shape = $urandom_range(0, 4);
        send_vector(rand_vec_comp(shape), rand_vec_comp(shape), rand_vec_comp(shape), 0, 0);
      end
    end
    in_valid <= 1'b0;
    drain();

    $display("covered %0d vectors (%0d checked, %0d small-angle) over several limit settings",
             n_sent, n_checked, n_identity);
    $display("including a long output hold that back-pressured the input");
    if (n_errors == 0 && pending_mats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/aam_pkg.sv
rtl/aam_delay.sv
rtl/aam_sqrt_cell.sv
rtl/aam_div_cell.sv
rtl/aam_horner_cell.sv
rtl/angle_axis_to_rotation_matrix_core.sv
rtl/aam_checker.sv
test/angle_axis_to_rotation_matrix_core_tb.sv
